[sv/mpr_pkg.sv]
// ----------------------------------------------------------------------------
// mpr_pkg
// Shared types, constants and helpers of the Motzkin path rank/unrank block.
// ----------------------------------------------------------------------------
package mpr_pkg;

  localparam int unsigned MaxWidth = 31;
  localparam int unsigned Rows     = MaxWidth + 2;
  localparam int unsigned Cols     = (MaxWidth + 2) / 2;
  localparam int unsigned RowW     = $clog2(Rows);
  localparam int unsigned ColW     = $clog2(Cols);
  localparam int unsigned WidthW   = $clog2(MaxWidth + 1);
  localparam int unsigned HeightW  = $clog2(Cols + 1);
  localparam int unsigned PosW     = RowW + 1;
  localparam int unsigned DataW    = 64;

  // step codes of a packed path
  localparam logic [1:0] DigUp   = 2'b00;
  localparam logic [1:0] DigDown = 2'b01;
  localparam logic [1:0] DigLvlO = 2'b10;
  localparam logic [1:0] DigLvlX = 2'b11;

  // operation codes of an input item
  localparam logic OpRank   = 1'b0;
  localparam logic OpUnrank = 1'b1;

  // control broadcast to every column cell while the table is built
  typedef struct packed {
    logic               clear;
    logic               we;
    logic [RowW-1:0]    row;
    logic [HeightW-1:0] height_cur;
    logic [HeightW-1:0] height_next;
    logic               diag_en;
    logic [ColW-1:0]    diag_col;
  } fill_ctrl_t;

  // diamond height of a row for width w; rows past the last step are empty
  function automatic logic [HeightW-1:0] col_height(input logic [WidthW-1:0] w,
                                                     input logic [RowW-1:0]   i);
    logic [RowW-1:0] w6;
    logic [RowW-1:0] half;
    logic [RowW-1:0] h;
    w6   = RowW'(w);
    half = (w6 + RowW'(1)) >> 1;
    if (i > w6) begin
      h = '0;
    end else if (i < half) begin
      h = i + RowW'(1);
    end else begin
      h = w6 + RowW'(1) - i;
    end
    return h[HeightW-1:0];
  endfunction

endpackage

[sv/mpr_cell.sv]
// ----------------------------------------------------------------------------
// mpr_cell
// One column of the count table: its row memory and the running entry that
// is handed to the neighbouring columns while the table is built.
// ----------------------------------------------------------------------------
module mpr_cell (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [mpr_pkg::ColW-1:0]              col_idx_i,
  input  mpr_pkg::fill_ctrl_t                   ctrl_i,
  input  logic [mpr_pkg::DataW-1:0]             left_i,
  input  logic [mpr_pkg::DataW-1:0]             right_i,
  input  logic [mpr_pkg::RowW-1:0]              rd_addr_i,
  output logic [mpr_pkg::DataW-1:0]             val_o,
  output logic [mpr_pkg::DataW-1:0]             rd_data_o
);
  import mpr_pkg::*;

  logic [DataW-1:0] cur_q, cur_d;
  logic [DataW-1:0] rd_data_q;
  logic [DataW-1:0] mem_q [Rows];
  logic [DataW-1:0] sum;
  logic             in_row;
  logic             is_diag;
  logic             past_diag;
  logic             use_right;

  // entry of this column for the current row
  always_comb begin
    in_row    = {1'b0, col_idx_i} < ctrl_i.height_cur;
    is_diag   = ctrl_i.diag_en && (col_idx_i == ctrl_i.diag_col);
    past_diag = ctrl_i.diag_en && (col_idx_i > ctrl_i.diag_col);
    use_right = (HeightW'(col_idx_i) + HeightW'(1)) != ctrl_i.height_next;
    sum       = {cur_q[DataW-2:0], 1'b0} + (use_right ? right_i : '0) + left_i;
    if (is_diag) begin
      cur_d = DataW'(1);
    end else if (in_row && !past_diag) begin
      cur_d = sum;
    end else begin
      cur_d = '0;
    end
  end

  // running entry, seen by the neighbours
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else if (ctrl_i.clear) begin
      cur_q <= '0;
    end else if (ctrl_i.we) begin
      cur_q <= cur_d;
    end
  end

  // column memory
  always_ff @(posedge clk_i) begin
    if (ctrl_i.we && !ctrl_i.clear) begin
      mem_q[ctrl_i.row] <= cur_d;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign val_o     = cur_q;
  assign rd_data_o = rd_data_q;

endmodule

[sv/motzkin_path_rank_unrank_top.sv]
// ----------------------------------------------------------------------------
// motzkin_path_rank_unrank_top
// Rank and unrank of two-colour Motzkin paths against a built count table.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid_i/cfg_ready_o, cfg_path_width_i) sets width w; it
//   is always ready, and every transfer rebuilds the count table.
//   in channel carries operation_i (0 rank, 1 unrank) and operand_value_i;
//   out channel returns result_value_o.
// Table build: after reset and after each width transfer, one row a cycle
//   across the 16 column cells; in_ready_o is low meanwhile.
// Walk: one path step per cycle, set by the single read port of each
//   column memory.
// Items: in_ready_o is high only while idle, so one item is walked at a time.
// Reset: width 8, table rebuilt, no result pending.
// Stall: the result sits in the output register; a new item may be taken
//   and worked on, and it waits finished until the register frees.
// ----------------------------------------------------------------------------
module motzkin_path_rank_unrank_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mpr_pkg::WidthW-1:0]         cfg_path_width_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               operation_i,
  input  logic [mpr_pkg::DataW-1:0]          operand_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [mpr_pkg::DataW-1:0]          result_value_o
);
  import mpr_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StFill = 3'd1;
  localparam logic [2:0] StLoad = 3'd2;
  localparam logic [2:0] StRun  = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [WidthW-1:0] width_q;
  logic [RowW-1:0]   row_q, row_d;
  logic [WidthW-1:0] step_q, step_d;
  logic              op_q;
  logic [DataW-1:0]  work_q, work_d;
  logic [DataW-1:0]  acc_q, acc_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              out_valid_q;
  logic [DataW-1:0]  out_q;

  logic              cfg_fire;
  logic              in_fire;
  logic              out_free;
  fill_ctrl_t        ctrl;
  logic [RowW-1:0]   rd_addr;
  logic [RowW-1:0]   rd_next;
  logic [RowW-1:0]   w6;
  logic [DataW-1:0]  cell_val [Cols];
  logic [DataW-1:0]  cell_rd  [Cols];
  logic [PosW-1:0]   pos_m1;
  logic [DataW-1:0]  here;
  logic [DataW-1:0]  below;
  logic [DataW-1:0]  two_here;
  logic [1:0]        digit;
  logic [RowW-1:0]   shamt;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;
  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign w6          = RowW'(width_q);

  // fill control broadcast
  always_comb begin
    ctrl.clear       = cfg_fire;
    ctrl.we          = (state_q == StFill) && !cfg_fire;
    ctrl.row         = row_q;
    ctrl.height_cur  = col_height(width_q, row_q);
    ctrl.height_next = col_height(width_q, row_q + RowW'(1));
    ctrl.diag_en     = (row_q <= w6) && (row_q >= (w6 - (w6 >> 1)));
    ctrl.diag_col    = ColW'(w6 - row_q);
  end

  // table read address: next row of the walk
  always_comb begin
    rd_next = RowW'(step_q) + RowW'(2);
    if (state_q == StRun) begin
      rd_addr = (rd_next > RowW'(Rows - 1)) ? RowW'(Rows - 1) : rd_next;
    end else begin
      rd_addr = RowW'(1);
    end
  end

  // row of column cells
  for (genvar c = 0; c < Cols; c++) begin : g_col
    logic [DataW-1:0] left_v;
    logic [DataW-1:0] right_v;
    if (c == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[c-1];
    end
    if (c == Cols - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[c+1];
    end
    mpr_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .col_idx_i (ColW'(c)),
      .ctrl_i    (ctrl),
      .left_i    (left_v),
      .right_i   (right_v),
      .rd_addr_i (rd_addr),
      .val_o     (cell_val[c]),
      .rd_data_o (cell_rd[c])
    );
  end

  // counts at the current height and one below; off the table reads zero
  always_comb begin
    pos_m1   = pos_q - PosW'(1);
    here     = (pos_q[PosW-1:ColW] == '0) ? cell_rd[pos_q[ColW-1:0]] : '0;
    below    = (pos_m1[PosW-1:ColW] == '0) ? cell_rd[pos_m1[ColW-1:0]] : '0;
    two_here = {here[DataW-2:0], 1'b0};
    digit    = work_q[DataW-1:DataW-2];
    shamt    = {~width_q, 1'b0};
  end

  // walk and sequencing
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    step_d  = step_q;
    work_d  = work_q;
    acc_d   = acc_q;
    pos_d   = pos_q;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          work_d  = operation_i ? '0 : (operand_value_i << shamt);
          acc_d   = operation_i ? operand_value_i : DataW'(1);
          pos_d   = '0;
          step_d  = '0;
          state_d = StLoad;
        end
      end
      StFill: begin
        if (row_q == '0) begin
          state_d = StIdle;
        end else begin
          row_d = row_q - RowW'(1);
        end
      end
      StLoad: begin
        state_d = StRun;
      end
      StRun: begin
        if (!op_q) begin
          // rank: add the counts of every smaller choice
          work_d = {work_q[DataW-3:0], 2'b00};
          case (digit)
            DigUp: begin
              acc_d = acc_q + two_here + ((pos_q != '0) ? below : '0);
              pos_d = pos_q + PosW'(1);
            end
            DigDown: begin
              acc_d = acc_q + two_here;
              pos_d = pos_q - PosW'(1);
            end
            DigLvlO: begin
              acc_d = acc_q + here;
            end
            default: begin
            end
          endcase
        end else begin
          // unrank: pick the digit whose block holds the number
          if (acc_q <= here) begin
            work_d = {work_q[DataW-3:0], DigLvlX};
          end else if (acc_q <= two_here) begin
            work_d = {work_q[DataW-3:0], DigLvlO};
            acc_d  = acc_q - here;
          end else if ((pos_q != '0) && (acc_q <= below + two_here)) begin
            work_d = {work_q[DataW-3:0], DigDown};
            acc_d  = acc_q - two_here;
            pos_d  = pos_q - PosW'(1);
          end else begin
            work_d = {work_q[DataW-3:0], DigUp};
            acc_d  = acc_q - two_here - ((pos_q != '0) ? below : '0);
            pos_d  = pos_q + PosW'(1);
          end
        end
        if (step_q == width_q) begin
          state_d = StDone;
        end else begin
          step_d = step_q + WidthW'(1);
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    if (cfg_fire) begin
      state_d = StFill;
      row_d   = RowW'(Rows - 1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StFill;
      row_q       <= RowW'(Rows - 1);
      width_q     <= WidthW'(8);
      step_q      <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      step_q  <= step_d;
      pos_q   <= pos_d;
      if (cfg_fire) begin
        width_q <= cfg_path_width_i;
      end
      if (state_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    acc_q  <= acc_d;
    if (in_fire) begin
      op_q <= operation_i;
    end
    if (state_q == StDone && out_free) begin
      out_q <= op_q ? work_q : acc_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_q;

  // no item is taken while the table is being built
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFill) |-> !in_ready_o)
    else $error("input taken during table build");

  // the build ends after row 0, the last row filled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFill && row_q == '0 && !cfg_valid_i) |=> (state_q == StIdle))
    else $error("table build did not finish");

  // the walk never runs past the last step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> (step_q <= width_q))
    else $error("walk ran past the last step");

  // a result is only loaded from the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == StDone))
    else $error("result loaded outside done state");

endmodule
